// ----- src/periodic_task_due_scanner_macros.svh -----
// Assertion macros used by the scanner's top-level RTL file.
`ifndef PERIODIC_TASK_DUE_SCANNER_MACROS_SVH
`define PERIODIC_TASK_DUE_SCANNER_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define PTDS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("scanner invariant violated");

// The consequent holds in the cycle after the antecedent.
`define PTDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scanner sequence violated");

`endif

// ----- src/ptds_pkg.sv -----
package ptds_pkg;

  localparam int MAX_TASK_SLOTS = 16;
  localparam int CNT_W = $clog2(MAX_TASK_SLOTS + 1);
  localparam int PERIOD_W = 32;
  localparam int TIME_W = 64;
  localparam int TASK_ID_W = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_ENABLE = 2'd1,
    ACT_DISABLE = 2'd2,
    ACT_RUN = 2'd3
  } action_t;

  localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd3;

  typedef struct packed {
    logic shift;
    logic flush;
    logic upd;
    logic add_we;
    logic en_we;
    logic en_val;
    logic [PERIOD_W-1:0] period;
  } cell_ctl_t;

endpackage

// ----- src/ptds_cell.sv -----
module ptds_cell
  import ptds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              tok_in,
  input  logic [TIME_W-1:0] now,
  output logic              tok_out,
  output logic              due
);

  logic                tok_r;
  logic [PERIOD_W-1:0] period_r;
  logic [TIME_W-1:0]   last_r;
  logic                en_r;
  logic [TIME_W-1:0]   elapsed;

  assign elapsed = now - last_r;
  assign due = tok_r && en_r && (elapsed >= {{(TIME_W - PERIOD_W){1'b0}}, period_r});
  assign tok_out = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else if (ctl.flush) begin
      tok_r <= 1'b0;
    end else if (ctl.shift) begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add_we) begin
      period_r <= ctl.period;
      last_r <= '0;
      en_r <= 1'b1;
    end else begin
      if (ctl.en_we) begin
        en_r <= ctl.en_val;
      end
      if (ctl.upd && due) begin
        last_r <= now;
      end
    end
  end

endmodule

// ----- src/periodic_task_due_scanner.sv -----
// Channel   Ports                                             Direction
// input     in_valid, in_stall, in_action, in_period,         in
//           in_target_id, in_now
// result    out_valid, out_stall, out_status, out_task_id,    out
//           out_last
//
// Add, enable and disable items give their one result in the cycle after acceptance.
// A run item walks a token along the cell row one slot per cycle while the result side
// does not stall, and a final step issues the done result.
// Reset clears the task count, the scan state and the output valid flag, with no clearing pass.
// A stall on the result side freezes the scan until the output register is free.
`include "periodic_task_due_scanner_macros.svh"

module periodic_task_due_scanner
  import ptds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_action,
  input  logic [PERIOD_W-1:0]  in_period,
  input  logic [TASK_ID_W-1:0] in_target_id,
  input  logic [TIME_W-1:0]    in_now,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [TASK_ID_W-1:0] out_task_id,
  output logic                 out_last
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      idx_r;
  logic [TIME_W-1:0]     now_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [TASK_ID_W-1:0]  out_task_id_r;
  logic                  out_last_r;

  logic                      out_free;
  logic                      acc;
  logic                      start;
  logic                      step;
  logic                      live;
  logic                      any_due;
  logic                      target_ok;
  action_t                   act;
  cell_ctl_t                 ctl [MAX_TASK_SLOTS];
  logic [MAX_TASK_SLOTS-1:0] tok_in_vec;
  logic [MAX_TASK_SLOTS-1:0] tok_vec;
  logic [MAX_TASK_SLOTS-1:0] due_vec;

  assign act = action_t'(in_action);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign acc = in_valid && !in_stall;
  assign start = acc && (act == ACT_RUN);
  assign step = (state_r == S_SCAN) && out_free;
  assign live = idx_r < count_r;
  assign any_due = |due_vec;
  assign target_ok = 32'(in_target_id) < 32'(count_r);

  always_comb begin
    for (int i = 0; i < MAX_TASK_SLOTS; i++) begin
      ctl[i].shift = start || step;
      ctl[i].flush = step && !live;
      ctl[i].upd = step && live;
      ctl[i].add_we = acc && (act == ACT_ADD) && (count_r == CNT_W'(i));
      ctl[i].en_we = acc && ((act == ACT_ENABLE) || (act == ACT_DISABLE)) &&
                     target_ok && (32'(in_target_id) == 32'(i));
      ctl[i].en_val = (act == ACT_ENABLE);
      ctl[i].period = in_period;
    end
  end

  always_comb begin
    tok_in_vec[0] = start;
    for (int i = 1; i < MAX_TASK_SLOTS; i++) begin
      tok_in_vec[i] = tok_vec[i-1];
    end
  end

  for (genvar g = 0; g < MAX_TASK_SLOTS; g++) begin : g_cell
    ptds_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[g]),
      .tok_in  (tok_in_vec[g]),
      .now     (now_r),
      .tok_out (tok_vec[g]),
      .due     (due_vec[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc && (act != ACT_RUN)) begin
            out_valid_r <= 1'b1;
            out_last_r <= 1'b1;
            if (act == ACT_ADD) begin
              if (count_r < CNT_W'(MAX_TASK_SLOTS)) begin
                out_status_r <= ST_ADDED;
                out_task_id_r <= TASK_ID_W'(count_r);
                count_r <= count_r + 1'b1;
              end else begin
                out_status_r <= ST_FULL;
                out_task_id_r <= '0;
              end
            end else begin
              out_status_r <= ST_DONE;
              out_task_id_r <= '0;
            end
          end else begin
            if (out_valid_r && !out_stall) begin
              out_valid_r <= 1'b0;
            end
            if (start) begin
              state_r <= S_SCAN;
              idx_r <= '0;
              now_r <= in_now;
            end
          end
        end
        S_SCAN: begin
          if (step && live && any_due) begin
            out_valid_r <= 1'b1;
            out_status_r <= ST_DUE;
            out_task_id_r <= TASK_ID_W'(idx_r);
            out_last_r <= 1'b0;
          end else if (step && !live) begin
            out_valid_r <= 1'b1;
            out_status_r <= ST_DONE;
            out_task_id_r <= '0;
            out_last_r <= 1'b1;
          end else if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
          end
          if (step) begin
            if (live) begin
              idx_r <= idx_r + 1'b1;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_task_id = out_task_id_r;
  assign out_last = out_last_r;

  `PTDS_ASSERT_ALWAYS(a_tok_onehot, $onehot0(tok_vec))
  `PTDS_ASSERT_ALWAYS(a_idle_no_tok, (state_r != S_IDLE) || (tok_vec == '0))
  `PTDS_ASSERT_ALWAYS(a_count_max, count_r <= CNT_W'(MAX_TASK_SLOTS))
  `PTDS_ASSERT_ALWAYS(a_due_not_last, !(out_valid_r && (out_status_r == ST_DUE)) || !out_last_r)
  `PTDS_ASSERT_NEXT(a_single_result, acc && (act != ACT_RUN), out_valid_r && out_last_r)

endmodule
